@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/clws_pkg.sv @@
// Shared types, codes and the transfer builder for the LCD write sequencer.
// Used by every module of the block; depends on nothing.
package clws_pkg;

   // Character codes with special meaning
   localparam logic [7:0] CHAR_NUL      = 8'd0;
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_FORMFEED = 8'd12;

   // Kinds of request after classification
   localparam logic [1:0] KIND_DATA     = 2'd0;
   localparam logic [1:0] KIND_NEWLINE  = 2'd1;
   localparam logic [1:0] KIND_FORMFEED = 2'd2;

   // LCD command bytes
   localparam logic [7:0] CMD_WAKE      = 8'h30;
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_SET_ADDR  = 8'h80;
   localparam logic [7:0] CMD_FUNCTION  = 8'h20;
   localparam logic [7:0] CMD_DISPLAY   = 8'h08;
   localparam logic [7:0] CMD_ENTRY     = 8'h04;

   localparam logic [3:0] PRE_POWER_UP  = 4'd15;

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_FUNCTION    = 3'd0;
   localparam logic [2:0] CSR_DISPLAY     = 3'd1;
   localparam logic [2:0] CSR_ENTRY       = 3'd2;
   localparam logic [2:0] CSR_FIRST_LINE  = 3'd3;
   localparam logic [2:0] CSR_SECOND_LINE = 3'd4;

   localparam int STEP_W     = 4;
   localparam logic [STEP_W-1:0] INIT_STEPS = 4'd7;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [2:0] function_bits;
      logic [2:0] display_bits;
      logic [1:0] entry_bits;
      logic [6:0] first_line_address;
      logic [6:0] second_line_address;
   } cfg_type;

   typedef struct packed {
      logic       init;
      logic [1:0] kind;
      logic [7:0] char_code;
   } queue_entry_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic [3:0] pre_wait_units;
      logic [1:0] post_wait_units;
      logic       last;
   } xfer_type;

   // Transfer number step of the run that one queued request causes.
   function automatic xfer_type build_xfer(queue_entry_type e, logic [STEP_W-1:0] step,
                                           cfg_type cfg);
      xfer_type x;
      logic [STEP_W-1:0] j;
      x = '0;
      j = step;
      if (e.init && step < INIT_STEPS) begin
         unique case (step[2:0])
            3'd0: begin
               x.bus_byte = CMD_WAKE;
               x.pre_wait_units = PRE_POWER_UP;
               x.post_wait_units = 2'd1;
            end
            3'd1, 3'd2: begin
               x.bus_byte = CMD_WAKE;
               x.post_wait_units = 2'd1;
            end
            3'd3: begin
               x.bus_byte = CMD_FUNCTION | {3'b000, cfg.function_bits, 2'b00};
               x.post_wait_units = 2'd2;
            end
            3'd4: begin
               x.bus_byte = CMD_DISPLAY | {5'b00000, cfg.display_bits};
               x.post_wait_units = 2'd2;
            end
            3'd5: begin
               x.bus_byte = CMD_CLEAR;
               x.pre_wait_units = 4'd1;
               x.post_wait_units = 2'd3;
            end
            default: begin
               x.bus_byte = CMD_ENTRY | {6'b000000, cfg.entry_bits};
               x.post_wait_units = 2'd2;
            end
         endcase
      end else begin
         if (e.init) begin
            j = step - INIT_STEPS;
         end
         unique case (e.kind)
            KIND_NEWLINE: begin
               x.bus_byte = CMD_SET_ADDR | {1'b0, cfg.second_line_address};
               x.post_wait_units = 2'd2;
               x.last = 1'b1;
            end
            KIND_FORMFEED: begin
               if (j == '0) begin
                  x.bus_byte = CMD_CLEAR;
                  x.post_wait_units = 2'd3;
               end else begin
                  x.bus_byte = CMD_SET_ADDR | {1'b0, cfg.first_line_address};
                  x.post_wait_units = 2'd2;
                  x.last = 1'b1;
               end
            end
            default: begin
               x.reg_select = 1'b1;
               x.bus_byte = e.char_code;
               x.post_wait_units = 2'd2;
               x.last = 1'b1;
            end
         endcase
      end
      return x;
   endfunction

endpackage

@@ rtl/char_lcd_write_sequencer_unit.sv @@
// Character LCD write sequencer: turns character requests into LCD bus transfers.
// Holds the configuration registers; instantiates clws_front, clws_fifo, clws_back.
//
// Use:
//   req_*  carries one character code per request. Code zero is accepted and dropped.
//   rsp_*  carries one bus transfer per beat: tuser is register select, tdata holds
//          the bus byte and both wait lengths, tlast marks the final transfer of a
//          request. A request yields 1 (data, newline), 2 (form feed) or, for the
//          first nonzero code after reset, 7 more init transfers in front.
//   csr_*  writes a configuration register by index; write only while idle.
// Path: an accepted request is written into the queue, loaded into the back-end
// entry register, and its transfers leave through the output register.
// Throughput: one transfer per cycle while rsp_tready is not held low; the
// back-end step counter walks the 1, 2, 8 or 9 transfers of a request; a 4-entry
// queue lets requests arrive while earlier runs are still being sent.
// Reset: clears queue, step state, output valid and the init-done flag; the
// configuration registers return to their reset values.
// Stall: rsp_tready held low freezes the output register; the queue keeps taking
// requests until it is full, then req_tready drops.
module char_lcd_write_sequencer_unit import clws_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] bus_byte, [11:8] pre_wait_units,
                                    // [13:12] post_wait_units, [15:14] zero
   output logic        rsp_tuser,   // [0] reg_select
   output logic        rsp_tlast,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [6:0]  csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   logic            push_valid, push_ready;
   queue_entry_type push_entry;
   logic            pop_valid, pop_ready;
   queue_entry_type pop_entry;
   xfer_type        rsp_xfer;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FUNCTION:    cfg_in.function_bits       = csr_wdata[2:0];
            CSR_DISPLAY:     cfg_in.display_bits        = csr_wdata[2:0];
            CSR_ENTRY:       cfg_in.entry_bits          = csr_wdata[1:0];
            CSR_FIRST_LINE:  cfg_in.first_line_address  = csr_wdata;
            CSR_SECOND_LINE: cfg_in.second_line_address = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.function_bits       <= 3'd7;
         cfg_ff.display_bits        <= 3'd6;
         cfg_ff.entry_bits          <= 2'd2;
         cfg_ff.first_line_address  <= 7'd0;
         cfg_ff.second_line_address <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   clws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   clws_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   clws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_xfer   (rsp_xfer)
   );

   assign rsp_tdata = {2'b00, rsp_xfer.post_wait_units, rsp_xfer.pre_wait_units,
                       rsp_xfer.bus_byte};
   assign rsp_tuser = rsp_xfer.reg_select;
   assign rsp_tlast = rsp_xfer.last;

endmodule

@@ rtl/clws_front.sv @@
// Front end: accepts character requests, drops zero codes, classifies the rest
// and marks the first one after reset for the init run. Uses clws_pkg.
module clws_front import clws_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,   // [7:0] char_code
   output logic            push_valid,
   input  logic            push_ready,
   output queue_entry_type push_entry
);

   logic ready_ff;
   logic ready_in;
   logic accept;
   logic is_char;

   assign req_tready = push_ready;
   assign accept     = req_tvalid && req_tready;
   assign is_char    = (req_tdata != CHAR_NUL);
   assign push_valid = req_tvalid && is_char;

   always_comb begin
      push_entry.init      = !ready_ff;
      push_entry.char_code = req_tdata;
      priority if (req_tdata == CHAR_NEWLINE) begin
         push_entry.kind = KIND_NEWLINE;
      end else if (req_tdata == CHAR_FORMFEED) begin
         push_entry.kind = KIND_FORMFEED;
      end else begin
         push_entry.kind = KIND_DATA;
      end
   end

   // Init run goes out once, ahead of the first nonzero request
   assign ready_in = ready_ff || (accept && is_char);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
      end
   end

endmodule

@@ rtl/clws_fifo.sv @@
// Short request queue between front and back ends, register based.
// Uses clws_pkg for the entry type and depth.
module clws_fifo import clws_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  queue_entry_type push_entry,
   output logic            pop_valid,
   input  logic            pop_ready,
   output queue_entry_type pop_entry
);

   queue_entry_type           entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]     count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/clws_back.sv @@
// Back end: steps through the transfers of each queued request into the output
// register, one per cycle if not stalled. Uses clws_pkg for types and build_xfer.
module clws_back import clws_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  queue_entry_type pop_entry,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output xfer_type        rsp_xfer
);

   logic              busy_ff, busy_in;
   queue_entry_type   entry_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              out_valid_ff, out_valid_in;
   xfer_type          out_ff;
   xfer_type          next_xfer;
   logic              out_free;
   logic              emit;

   assign next_xfer = build_xfer(entry_ff, step_ff, cfg);
   assign out_free  = !out_valid_ff || rsp_tready;
   assign emit      = busy_ff && out_free;
   // Load the next request as soon as the current run ends
   assign pop_ready = !busy_ff || (emit && next_xfer.last);

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (emit) begin
         out_valid_in = 1'b1;
         step_in      = step_ff + 1'b1;
         if (next_xfer.last) begin
            busy_in = 1'b0;
         end
      end
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_valid && pop_ready) begin
         entry_ff <= pop_entry;
      end
      if (emit) begin
         out_ff <= next_xfer;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_xfer   = out_ff;

endmodule

@@ rtl/clws_checker.sv @@
// Port-level checks on the LCD write sequencer's result stream, bound to the top.
// Depends on assert_macros.svh and clws_pkg.
`include "assert_macros.svh"

module clws_checker import clws_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   logic stalled;
   logic taken;
   logic power_up;
   logic data_ok;
   logic power_up_ok;
   logic wake_ok;

   assign stalled     = rsp_tvalid && !rsp_tready;
   assign taken       = rsp_tvalid && rsp_tready;
   assign power_up    = rsp_tvalid && (rsp_tdata[11:8] == PRE_POWER_UP);
   // Upper byte: zero pad, post wait of two, no pre wait
   assign data_ok     = (rsp_tdata[15:8] == 8'h20) && rsp_tlast;
   assign power_up_ok = (rsp_tdata[7:0] == CMD_WAKE) && !rsp_tuser && !rsp_tlast;
   assign wake_ok     = !rsp_tvalid ||
                        ((rsp_tdata[7:0] == CMD_WAKE) && (rsp_tdata[11:8] == 4'd0));

   // Hold a stalled transfer
   `ASSERT_CLK(a_rsp_hold, clock, reset, stalled |=> rsp_tvalid, "rsp dropped while stalled")

   // Data writes carry no pre wait, post wait of two, and end their request
   `ASSERT_CLK(a_data_timing, clock, reset, rsp_tvalid && rsp_tuser |-> data_ok, "bad data timing")

   // Power-up wait appears only on a wake command, never the last of a run
   `ASSERT_CLK(a_power_up, clock, reset, power_up |-> power_up_ok, "power-up on wrong transfer")

   // The transfer after a power-up wait is another wake command
   `ASSERT_CLK(a_wake_follows, clock, reset, taken && power_up |=> wake_ok, "init run out of order")

endmodule

bind char_lcd_write_sequencer_unit clws_checker u_clws_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/sv/char_lcd_write_sequencer_unit_test.sv @@
// Self-checking test of the character LCD write sequencer: directed and random requests,
// each predicted into its LCD bus transfers and checked against the result stream.
// Depends on clws_pkg and char_lcd_write_sequencer_unit.
`timescale 1ns / 100ps

module char_lcd_write_sequencer_unit_test;
   import clws_pkg::*;

   localparam int         CYCLE_LIMIT    = 250000;
   localparam int         REPORT_LIMIT   = 10;
   localparam int         SETTLE_CYCLES  = 8;
   localparam int         MAX_GAP        = 8;
   localparam logic [2:0] CSR_LAST_INDEX = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wen = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;

   // Shadow of the block: its registers, the init-done flag and the transfers still owed
   cfg_type   lcd_cfg;
   bit        lcd_initialized;
   xfer_type  owed_xfers[$];
   int        mismatch_count = 0;
   int        cycle_count = 0;
   bit        throttle = 1'b1;

   char_lcd_write_sequencer_unit i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .csr_wen, .csr_index, .csr_wdata
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void owe_xfer(logic rs, logic [7:0] bus, logic [3:0] pre,
                                    logic [1:0] post, logic fin);
      xfer_type x;
      x.reg_select = rs;
      x.bus_byte = bus;
      x.pre_wait_units = pre;
      x.post_wait_units = post;
      x.last = fin;
      owed_xfers.push_back(x);
   endfunction

   // Append the transfers that one accepted character code causes.
   function automatic void predict_lcd_xfers(logic [7:0] code);
      if (code == CHAR_NUL) begin
         return;
      end
      if (!lcd_initialized) begin
         owe_xfer(1'b0, CMD_WAKE, PRE_POWER_UP, 2'd1, 1'b0);
         owe_xfer(1'b0, CMD_WAKE, 4'd0, 2'd1, 1'b0);
         owe_xfer(1'b0, CMD_WAKE, 4'd0, 2'd1, 1'b0);
         owe_xfer(1'b0, CMD_FUNCTION | (8'(lcd_cfg.function_bits) << 2), 4'd0, 2'd2, 1'b0);
         owe_xfer(1'b0, CMD_DISPLAY | 8'(lcd_cfg.display_bits), 4'd0, 2'd2, 1'b0);
         owe_xfer(1'b0, CMD_CLEAR, 4'd1, 2'd3, 1'b0);
         owe_xfer(1'b0, CMD_ENTRY | 8'(lcd_cfg.entry_bits), 4'd0, 2'd2, 1'b0);
         lcd_initialized = 1'b1;
      end
      if (code == CHAR_NEWLINE) begin
         owe_xfer(1'b0, CMD_SET_ADDR | 8'(lcd_cfg.second_line_address), 4'd0, 2'd2, 1'b1);
      end else if (code == CHAR_FORMFEED) begin
         owe_xfer(1'b0, CMD_CLEAR, 4'd0, 2'd3, 1'b0);
         owe_xfer(1'b0, CMD_SET_ADDR | 8'(lcd_cfg.first_line_address), 4'd0, 2'd2, 1'b1);
      end else begin
         owe_xfer(1'b1, code, 4'd0, 2'd2, 1'b1);
      end
   endfunction

   function automatic void apply_reg(logic [2:0] index, logic [6:0] value);
      case (index)
         CSR_FUNCTION:    lcd_cfg.function_bits = value[2:0];
         CSR_DISPLAY:     lcd_cfg.display_bits = value[2:0];
         CSR_ENTRY:       lcd_cfg.entry_bits = value[1:0];
         CSR_FIRST_LINE:  lcd_cfg.first_line_address = value;
         CSR_SECOND_LINE: lcd_cfg.second_line_address = value;
         default: ;
      endcase
   endfunction

   // Leaves csr_wen high so that writes can follow back to back.
   task automatic write_reg(input logic [2:0] index, input logic [6:0] value);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg(index, value);
   endtask

   task automatic program_regs(input logic [6:0] fn, input logic [6:0] disp,
                               input logic [6:0] entry, input logic [6:0] line1,
                               input logic [6:0] line2);
      write_reg(CSR_FUNCTION, fn);
      write_reg(CSR_DISPLAY, disp);
      write_reg(CSR_ENTRY, entry);
      write_reg(CSR_FIRST_LINE, line1);
      write_reg(CSR_SECOND_LINE, line2);
      // a write to an unused index must leave every register alone
      write_reg(3'($urandom_range(CSR_SECOND_LINE + 1, CSR_LAST_INDEX)),
                7'($urandom_range(0, 127)));
      csr_wen <= 1'b0;
   endtask

   task automatic program_random_regs();
      program_regs(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
   endtask

   // Valid stays high after acceptance; it drops only ahead of a gap or when draining.
   task automatic send_char(input logic [7:0] code);
      int gap;
      gap = throttle ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_lcd_xfers(code);
   endtask

   // Drop valid, wait for every owed transfer, then let the block settle.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      while (owed_xfers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_code();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 18) begin
         return CHAR_NEWLINE;
      end else if (roll < 30) begin
         return CHAR_FORMFEED;
      end else if (roll < 38) begin
         return CHAR_NUL;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Init run once per reset: either with the reset values or freshly written ones,
   // led by zero codes that must neither emit nor trigger it.
   task automatic test_init_run();
      if ($urandom_range(0, 1) == 1) begin
         program_random_regs();
      end
      send_char(CHAR_NUL);
      send_char(CHAR_NUL);
      send_char(8'($urandom_range(1, 255)));
      wait_for_idle();
   endtask

   task automatic test_special_codes();
      logic [7:0] codes[$];
      codes = '{8'hFF, 8'h01, CHAR_NEWLINE, CHAR_FORMFEED, CHAR_NUL, 8'h80, 8'h7F,
                8'h0B, 8'h0D, 8'h09, CHAR_FORMFEED, CHAR_FORMFEED, CHAR_NEWLINE,
                8'hAA, 8'h55};
      foreach (codes[i]) begin
         send_char(codes[i]);
      end
      wait_for_idle();
   endtask

   task automatic test_register_extremes();
      program_regs(7'd0, 7'd0, 7'd0, 7'd0, 7'd0);
      send_char(CHAR_NEWLINE);
      send_char(CHAR_FORMFEED);
      send_char(8'h41);
      wait_for_idle();
      program_regs(7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
      send_char(CHAR_NEWLINE);
      send_char(CHAR_FORMFEED);
      wait_for_idle();
   endtask

   task automatic test_random_traffic();
      int sent;
      logic [7:0] code;
      for (int phase = 0; phase < 6; phase++) begin
         throttle = (phase != 1 && phase != 4);
         program_random_regs();
         sent = 0;
         while (sent < 48) begin
            code = pick_code();
            send_char(code);
            if (code != CHAR_NUL) begin
               sent++;
            end
         end
         wait_for_idle();
      end
      throttle = 1'b1;
   endtask

   // Result side: random stall ahead of each transfer while throttle is set.
   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = throttle ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      xfer_type got;
      xfer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.reg_select = rsp_tuser;
         got.bus_byte = rsp_tdata[7:0];
         got.pre_wait_units = rsp_tdata[11:8];
         got.post_wait_units = rsp_tdata[13:12];
         got.last = rsp_tlast;
         if (owed_xfers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: unexpected transfer rs=%0b byte=%02h pre=%0d post=%0d last=%0b",
                        $realtime, got.reg_select, got.bus_byte, got.pre_wait_units,
                        got.post_wait_units, got.last);
            end
         end else begin
            want = owed_xfers.pop_front();
            if (got.reg_select !== want.reg_select || got.bus_byte !== want.bus_byte ||
                got.pre_wait_units !== want.pre_wait_units ||
                got.post_wait_units !== want.post_wait_units || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("%0t: transfer differs: want rs=%0b byte=%02h pre=%0d post=%0d last=%0b",
                           $realtime, want.reg_select, want.bus_byte, want.pre_wait_units,
                           want.post_wait_units, want.last);
                  $display("%0t:                   got  rs=%0b byte=%02h pre=%0d post=%0d last=%0b",
                           $realtime, got.reg_select, got.bus_byte, got.pre_wait_units,
                           got.post_wait_units, got.last);
               end
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cycle limit reached with %0d transfers outstanding", owed_xfers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      lcd_cfg.function_bits = 3'd7;
      lcd_cfg.display_bits = 3'd6;
      lcd_cfg.entry_bits = 2'd2;
      lcd_cfg.first_line_address = 7'd0;
      lcd_cfg.second_line_address = 7'd64;
      lcd_initialized = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_init_run();
      test_special_codes();
      test_register_extremes();
      test_random_traffic();

      wait_for_idle();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && owed_xfers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
